[design/ids_pkg.sv]
// ids_pkg: shared types and constants for the indexed deque store.
// Field widths of the command and response transactions, opcodes, status codes
// and sequencer states. No dependencies.
package ids_pkg;

  localparam int OP_BITS  = 3;
  localparam int VAL_BITS = 32;
  localparam int POS_BITS = 6;
  localparam int CNT_BITS = 7;
  localparam int ST_BITS  = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_READ       = 3'd6,
    OP_CLEAR      = 3'd7
  } ids_op_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } ids_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_FINAL,
    S_DONE
  } ids_state_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                  valid;
    logic [VAL_BITS-1:0]   read_value;
    logic [CNT_BITS-1:0]   count;
    ids_status_t           status;
  } ids_result_t;

endpackage

[design/ids_if.sv]
// ids_if: valid/ready channel interfaces for command and response transactions.
// Depends on ids_pkg for field widths.
interface ids_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [ids_pkg::OP_BITS-1:0]         operation;
  logic signed [ids_pkg::VAL_BITS-1:0] value;
  logic [ids_pkg::POS_BITS-1:0]        position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface ids_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ids_pkg::VAL_BITS-1:0] read_value;
  logic [ids_pkg::CNT_BITS-1:0]        count;
  logic [ids_pkg::ST_BITS-1:0]         status;

  modport source (output valid, output read_value, output count, output status,
                  input ready);
  modport sink (input valid, input read_value, input count, input status,
                output ready);
endinterface

[design/ids_ram.sv]
// ids_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module ids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ids_seq.sv]
// ids_seq: command sequencer of the indexed deque store. Holds head and count,
// drives the element RAM and shifts entries one per cycle on insert and erase.
// Depends on ids_pkg and ids_if.
module ids_seq #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  ids_cmd_if.sink                     cmd,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [VALUE_WIDTH-1:0]      ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [VALUE_WIDTH-1:0]      ram_rdata,
  output ids_pkg::ids_result_t        res,
  input  logic                        out_free
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > ids_pkg::POS_BITS) ? CW : ids_pkg::POS_BITS;
  localparam int VB = ids_pkg::VAL_BITS;

  ids_pkg::ids_state_t           state, state_next;
  ids_pkg::ids_op_t              op_r, op_r_next;
  logic [VALUE_WIDTH-1:0]        val_r, val_r_next;
  logic [ids_pkg::POS_BITS-1:0]  pos_r, pos_r_next;
  logic [PW-1:0]                 head, head_next;
  logic [CW-1:0]                 count, count_next;
  logic [PW-1:0]                 wr_slot, wr_slot_next;
  logic [PW-1:0]                 rd_slot, rd_slot_next;
  logic [CW-1:0]                 remain, remain_next;
  logic [VB-1:0]                 rd_val, rd_val_next;
  ids_pkg::ids_status_t          status_r, status_r_next;

  logic [VALUE_WIDTH-1:0] val_in;
  logic [VB-1:0]          rd_ext;

  if (VALUE_WIDTH <= VB) begin : g_in_narrow
    assign val_in = cmd.value[VALUE_WIDTH-1:0];
  end else begin : g_in_wide
    assign val_in = {{(VALUE_WIDTH-VB){cmd.value[VB-1]}}, cmd.value};
  end

  if (VALUE_WIDTH >= VB) begin : g_out_wide
    assign rd_ext = ram_rdata[VB-1:0];
  end else begin : g_out_narrow
    assign rd_ext = {{(VB-VALUE_WIDTH){ram_rdata[VALUE_WIDTH-1]}}, ram_rdata};
  end

  // physical slot of a logical index, modulo CAPACITY
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] h,
                                            input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return PW'(s);
  endfunction

  function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] s);
    return (s == PW'(CAPACITY - 1)) ? '0 : s + PW'(1);
  endfunction

  function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] s);
    return (s == '0) ? PW'(CAPACITY - 1) : s - PW'(1);
  endfunction

  logic          full, empty, pos_gt, pos_ge;
  logic [CW-1:0] pos_cw;
  logic [PW-1:0] slot_cnt, slot_pos, slot_one, head_dec, rd_step;

  always_comb begin
    full     = (count == CW'(CAPACITY));
    empty    = (count == '0);
    pos_gt   = XW'(pos_r) > XW'(count);
    pos_ge   = XW'(pos_r) >= XW'(count);
    pos_cw   = CW'(pos_r);
    slot_cnt = slot_of(head, count);
    slot_pos = slot_of(head, pos_cw);
    slot_one = slot_of(head, CW'(1));
    head_dec = slot_dec(head);
    // erase walks up, insert walks down
    rd_step  = (op_r == ids_pkg::OP_ERASE) ? slot_inc(rd_slot) : slot_dec(rd_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ids_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    op_r     <= op_r_next;
    val_r    <= val_r_next;
    pos_r    <= pos_r_next;
    wr_slot  <= wr_slot_next;
    rd_slot  <= rd_slot_next;
    remain   <= remain_next;
    rd_val   <= rd_val_next;
    status_r <= status_r_next;
  end

  always_comb begin
    state_next    = state;
    op_r_next     = op_r;
    val_r_next    = val_r;
    pos_r_next    = pos_r;
    head_next     = head;
    count_next    = count;
    wr_slot_next  = wr_slot;
    rd_slot_next  = rd_slot;
    remain_next   = remain;
    rd_val_next   = rd_val;
    status_r_next = status_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_slot;
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_slot;
    cmd.ready     = 1'b0;

    unique case (state)
      ids_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          op_r_next   = ids_pkg::ids_op_t'(cmd.operation);
          val_r_next  = val_in;
          pos_r_next  = cmd.position;
          rd_val_next = '0;
          state_next  = ids_pkg::S_EXEC;
        end
      end

      ids_pkg::S_EXEC: begin
        status_r_next = ids_pkg::ST_OK;
        state_next    = ids_pkg::S_DONE;
        unique case (op_r)
          ids_pkg::OP_PUSH_BACK: begin
            if (full) begin
              status_r_next = ids_pkg::ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = slot_cnt;
              count_next = count + CW'(1);
            end
          end
          ids_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              status_r_next = ids_pkg::ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = head_dec;
              head_next  = head_dec;
              count_next = count + CW'(1);
            end
          end
          ids_pkg::OP_POP_BACK: begin
            if (empty) begin
              status_r_next = ids_pkg::ST_EMPTY;
            end else begin
              count_next = count - CW'(1);
            end
          end
          ids_pkg::OP_POP_FRONT: begin
            if (empty) begin
              status_r_next = ids_pkg::ST_EMPTY;
            end else begin
              head_next  = slot_one;
              count_next = count - CW'(1);
            end
          end
          ids_pkg::OP_INSERT: begin
            if (pos_gt) begin
              status_r_next = ids_pkg::ST_BOUNDS;
            end else if (full) begin
              status_r_next = ids_pkg::ST_FULL;
            end else if (pos_cw == count) begin
              ram_we     = 1'b1;
              ram_waddr  = slot_cnt;
              count_next = count + CW'(1);
            end else begin
              remain_next  = count - pos_cw;
              wr_slot_next = slot_cnt;
              rd_slot_next = slot_dec(slot_cnt);
              ram_re       = 1'b1;
              ram_raddr    = slot_dec(slot_cnt);
              state_next   = ids_pkg::S_SHIFT;
            end
          end
          ids_pkg::OP_ERASE: begin
            if (pos_ge) begin
              status_r_next = ids_pkg::ST_BOUNDS;
            end else if (pos_cw == count - CW'(1)) begin
              count_next = count - CW'(1);
            end else begin
              remain_next  = count - CW'(1) - pos_cw;
              wr_slot_next = slot_pos;
              rd_slot_next = slot_inc(slot_pos);
              ram_re       = 1'b1;
              ram_raddr    = slot_inc(slot_pos);
              state_next   = ids_pkg::S_SHIFT;
            end
          end
          ids_pkg::OP_READ: begin
            if (pos_ge) begin
              status_r_next = ids_pkg::ST_BOUNDS;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = slot_pos;
              state_next = ids_pkg::S_READ;
            end
          end
          ids_pkg::OP_CLEAR: begin
            count_next = '0;
            head_next  = '0;
          end
        endcase
      end

      ids_pkg::S_READ: begin
        rd_val_next = rd_ext;
        state_next  = ids_pkg::S_DONE;
      end

      // one entry moves per cycle; next read overlaps current write
      ids_pkg::S_SHIFT: begin
        ram_we       = 1'b1;
        ram_waddr    = wr_slot;
        ram_wdata    = ram_rdata;
        wr_slot_next = rd_slot;
        rd_slot_next = rd_step;
        remain_next  = remain - CW'(1);
        if (remain != CW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = rd_step;
        end else if (op_r == ids_pkg::OP_INSERT) begin
          state_next = ids_pkg::S_FINAL;
        end else begin
          count_next = count - CW'(1);
          state_next = ids_pkg::S_DONE;
        end
      end

      ids_pkg::S_FINAL: begin
        ram_we     = 1'b1;
        ram_waddr  = wr_slot;
        count_next = count + CW'(1);
        state_next = ids_pkg::S_DONE;
      end

      ids_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ids_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ids_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.valid      = (state == ids_pkg::S_DONE);
    res.read_value = rd_val;
    res.count      = ids_pkg::CNT_BITS'(count);
    res.status     = status_r;
  end

endmodule

[design/indexed_deque_store.sv]
// indexed_deque_store: circular double-ended queue with indexed insert, erase and read.
// A command goes from IDLE to EXEC, then READ for a read, or SHIFT while an insert/erase
//   moves entries and FINAL when an insert moves any, then DONE and the output register.
// One command at a time: the next is taken only after DONE hands its result on. The RAM
//   shift moves one entry per cycle. Sync active-high rst empties the store.
// Depends on ids_pkg, ids_if, ids_ram and ids_seq.
module indexed_deque_store #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ids_cmd_if.sink   cmd,
  ids_rsp_if.source rsp
);

  localparam int PW = $clog2(CAPACITY);

  // Element storage: one synchronous RAM, one write and one read port.
  // Contents are not cleared; only live entries are ever read back.
  logic                   ram_we;
  logic [PW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [PW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  ids_pkg::ids_result_t res;
  logic                 out_free;

  ids_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: takes one command transaction at a time, owns head/count,
  // and walks the RAM during insert/erase shifts.
  ids_seq #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res),
    .out_free  (out_free)
  );

  // Output register: decouples the response channel so the sequencer can
  // go back to idle and accept the next command while a response waits.
  logic                         rsp_valid;
  logic [ids_pkg::VAL_BITS-1:0] rsp_value;
  logic [ids_pkg::CNT_BITS-1:0] rsp_count;
  ids_pkg::ids_status_t         rsp_status;

  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (res.valid && out_free) begin
      rsp_value  <= res.read_value;
      rsp_count  <= res.count;
      rsp_status <= res.status;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.count      = rsp_count;
  assign rsp.status     = rsp_status;

endmodule

[verif/tb.sv]
// tb: self-checking testbench for indexed_deque_store (circular deque with indexed access).
// Drives random and directed command transactions, predicts each response with a shadow deque.
// Depends on ids_pkg, ids_if and the indexed_deque_store RTL.
module tb;
  import ids_pkg::*;

  localparam int CAP         = 64;
  localparam int VW          = 32;
  localparam int RAND_ITEMS  = 500;
  localparam int CYCLE_LIMIT = 500000;

  // one command transaction as queued for the driver
  typedef struct {
    ids_op_t           op;
    logic [VW-1:0]     value;
    logic [POS_BITS-1:0] pos;
    bit                hold_for_idle;  // driver waits for every response first
  } deque_cmd_t;

  // one predicted response transaction
  typedef struct packed {
    logic signed [VAL_BITS-1:0] read_value;
    logic [CNT_BITS-1:0]        count;
    ids_status_t                status;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ids_cmd_if cmd_ch();
  ids_rsp_if rsp_ch();

  indexed_deque_store #(
    .CAPACITY    (CAP),
    .VALUE_WIDTH (VW)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Shadow deque: same circular layout as the block, head + count.
  // ------------------------------------------------------------------
  logic [VW-1:0]       shadow_mem [CAP];
  logic [POS_BITS-1:0] shadow_head;
  int                  shadow_count;

  deque_cmd_t cmd_backlog [$];   // commands not yet offered to the block
  deque_rsp_t awaited_rsps [$];  // responses predicted, not yet seen

  int  failures    = 0;
  int  cycle_count = 0;
  bit  cmd_fired   = 1'b0;       // command transaction at the last rising edge

  function automatic logic [POS_BITS-1:0] slot_of_index(int idx);
    return POS_BITS'((int'(shadow_head) + idx) % CAP);
  endfunction

  // Apply one command to the shadow deque and return the response it yields.
  // A failing command leaves the shadow state untouched.
  function automatic deque_rsp_t apply_command(ids_op_t op, logic [VW-1:0] value,
                                               logic [POS_BITS-1:0] pos);
    deque_rsp_t r;
    int         p;
    r.read_value = '0;
    r.status     = ST_OK;
    p            = int'(pos);
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[slot_of_index(shadow_count)] = value;
          shadow_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = slot_of_index(CAP - 1);  // one slot back, wrapping
          shadow_mem[shadow_head] = value;
          shadow_count++;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = slot_of_index(1);
          shadow_count--;
        end
      end
      OP_INSERT: begin
        // bounds check wins over the full check
        if (p > shadow_count) begin
          r.status = ST_BOUNDS;
        end else if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--)
            shadow_mem[slot_of_index(i)] = shadow_mem[slot_of_index(i - 1)];
          shadow_mem[slot_of_index(p)] = value;
          shadow_count++;
        end
      end
      OP_ERASE: begin
        if (p >= shadow_count) begin
          r.status = ST_BOUNDS;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++)
            shadow_mem[slot_of_index(i)] = shadow_mem[slot_of_index(i + 1)];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (p >= shadow_count) r.status = ST_BOUNDS;
        else r.read_value = shadow_mem[slot_of_index(p)];
      end
      default: begin  // clear
        shadow_count = 0;
        shadow_head  = '0;
      end
    endcase
    r.count = CNT_BITS'(shadow_count);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus generation. gen_count tracks the element count the queued
  // commands will leave behind, so positions can aim at live entries.
  // ------------------------------------------------------------------
  int gen_count  = 0;
  int rand_added = 0;

  function automatic int count_after(ids_op_t op, int pos, int n);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: return (n < CAP) ? n + 1 : n;
      OP_POP_BACK, OP_POP_FRONT:   return (n > 0) ? n - 1 : n;
      OP_INSERT:                   return (pos <= n && n < CAP) ? n + 1 : n;
      OP_ERASE:                    return (pos < n) ? n - 1 : n;
      OP_READ:                     return n;
      default:                     return 0;
    endcase
  endfunction

  task automatic queue_cmd(ids_op_t op, logic [VW-1:0] value, int pos, bit hold = 1'b0);
    deque_cmd_t c;
    c.op            = op;
    c.value         = value;
    c.pos           = POS_BITS'(pos);
    c.hold_for_idle = hold;
    cmd_backlog.insert(cmd_backlog.size(), c);
    gen_count = count_after(op, pos, gen_count);
    rand_added++;
  endtask

  // mostly full-range random data, now and then an extreme
  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // position in [0, hi] most of the time, otherwise anywhere in the field
  function automatic int rand_pos(int hi);
    if (hi < 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, (hi > 63) ? 63 : hi);
  endfunction

  task automatic queue_mixed_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)      queue_cmd(OP_PUSH_BACK, rand_value(), $urandom_range(0, 63));
    else if (r < 32) queue_cmd(OP_PUSH_FRONT, rand_value(), $urandom_range(0, 63));
    else if (r < 44) queue_cmd(OP_INSERT, rand_value(), rand_pos(gen_count));
    else if (r < 54) queue_cmd(OP_POP_BACK, rand_value(), $urandom_range(0, 63));
    else if (r < 62) queue_cmd(OP_POP_FRONT, rand_value(), $urandom_range(0, 63));
    else if (r < 72) queue_cmd(OP_ERASE, rand_value(), rand_pos(gen_count - 1));
    else if (r < 97) queue_cmd(OP_READ, rand_value(), rand_pos(gen_count - 1));
    else             queue_cmd(OP_CLEAR, rand_value(), $urandom_range(0, 63));
  endtask

  initial begin
    int phase;
    int n;

    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_READ;
    cmd_ch.value     = '0;
    cmd_ch.position  = '0;
    rsp_ch.ready     = 1'b0;
    shadow_head      = '0;
    shadow_count     = 0;

    // Directed: empty-deque errors first, then extremes, append, mid insert,
    // reads at both ends and past the end, erases, clear, head wrap.
    queue_cmd(OP_READ,       32'h0,         0);   // read when empty
    queue_cmd(OP_POP_BACK,   32'h0,         0);   // pop when empty
    queue_cmd(OP_POP_FRONT,  32'h0,         0);
    queue_cmd(OP_ERASE,      32'h0,         0);   // erase when empty
    queue_cmd(OP_INSERT,     32'h1,         1);   // insert past count
    queue_cmd(OP_INSERT,     32'h7FFF_FFFF, 0);   // insert into empty deque
    queue_cmd(OP_PUSH_BACK,  32'h8000_0000, 63);
    queue_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, 63);
    queue_cmd(OP_PUSH_BACK,  32'h0,         0);
    queue_cmd(OP_INSERT,     32'h5A5A_5A5A, 4);   // position == count appends
    queue_cmd(OP_INSERT,     32'hA5A5_A5A5, 2);   // mid insert shifts the tail
    queue_cmd(OP_READ,       32'h0,         0);
    queue_cmd(OP_READ,       32'h0,         5);   // last live entry
    queue_cmd(OP_READ,       32'h0,         6);   // one past the end
    queue_cmd(OP_READ,       32'hFFFF_FFFF, 63);
    queue_cmd(OP_ERASE,      32'h0,         2);
    queue_cmd(OP_ERASE,      32'h0,         4);   // erase the last entry
    queue_cmd(OP_ERASE,      32'h0,         0);
    queue_cmd(OP_INSERT,     32'h1234_5678, 63);  // far out of range
    queue_cmd(OP_POP_BACK,   32'h0,         0);
    queue_cmd(OP_POP_FRONT,  32'h0,         0);
    queue_cmd(OP_CLEAR,      32'h0,         0);
    queue_cmd(OP_READ,       32'h0,         0);   // read after clear
    queue_cmd(OP_PUSH_FRONT, 32'hDEAD_BEEF, 0);   // head wraps to the top slot
    queue_cmd(OP_READ,       32'h0,         0);

    // Random part; the first item waits until the block has drained.
    rand_added = 0;
    queue_cmd(OP_READ, rand_value(), rand_pos(gen_count - 1), 1'b1);
    while (rand_added < RAND_ITEMS) begin
      phase = $urandom_range(0, 9);
      if (phase < 2) begin
        // fill to capacity, then hit the full cases
        while (gen_count < CAP) begin
          case ($urandom_range(0, 2))
            0:       queue_cmd(OP_PUSH_BACK, rand_value(), $urandom_range(0, 63));
            1:       queue_cmd(OP_PUSH_FRONT, rand_value(), $urandom_range(0, 63));
            default: queue_cmd(OP_INSERT, rand_value(), rand_pos(gen_count));
          endcase
        end
        queue_cmd(OP_PUSH_BACK, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_PUSH_FRONT, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_INSERT, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_READ, rand_value(), 63);
        queue_cmd(OP_READ, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_ERASE, rand_value(), $urandom_range(0, 63));
      end else if (phase == 2) begin
        // drain to empty, then the empty cases
        while (gen_count > 0) begin
          case ($urandom_range(0, 2))
            0:       queue_cmd(OP_POP_BACK, rand_value(), $urandom_range(0, 63));
            1:       queue_cmd(OP_POP_FRONT, rand_value(), $urandom_range(0, 63));
            default: queue_cmd(OP_ERASE, rand_value(), rand_pos(gen_count - 1));
          endcase
        end
        queue_cmd(OP_POP_BACK, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_POP_FRONT, rand_value(), $urandom_range(0, 63));
        queue_cmd(OP_READ, rand_value(), $urandom_range(0, 63));
      end else if (phase == 3) begin
        queue_cmd(OP_CLEAR, rand_value(), $urandom_range(0, 63),
                  $urandom_range(0, 3) == 0);
      end else begin
        n = $urandom_range(10, 30);
        repeat (n) queue_mixed_op();
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for all commands to go in, then for every response
    while (cmd_backlog.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (awaited_rsps.size() != 0) @(posedge clk);
    // room for any stray response
    repeat (CAP + 16) @(posedge clk);
    if (failures == 0) begin
      $display("indexed_deque_store: match");
    end else begin
      $display("indexed_deque_store: mismatch");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Inputs
  // change only at the falling edge; each signal is assigned once per edge.
  // ------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  deque_cmd_t next_cmd;

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_fired) begin
      // offered but not taken yet: hold the transaction steady
    end else if (gap_left > 0) begin
      gap_left--;
      cmd_ch.valid <= 1'b0;
    end else if (cmd_backlog.size() == 0 ||
                 (cmd_backlog[0].hold_for_idle && awaited_rsps.size() != 0)) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      next_cmd           = cmd_backlog[0];
      cmd_backlog.delete(0);
      cmd_ch.valid     <= 1'b1;
      cmd_ch.operation <= next_cmd.op;
      cmd_ch.value     <= next_cmd.value;
      cmd_ch.position  <= next_cmd.pos;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  end

  // ------------------------------------------------------------------
  // Response ready: segments of always-ready, coin-flip, hard stall and
  // a periodic pattern, each of random length.
  // ------------------------------------------------------------------
  int seg_mode = 0;
  int seg_left = 0;

  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 3);
      seg_left = (seg_mode == 2) ? $urandom_range(1, 8) : $urandom_range(4, 40);
    end
    seg_left--;
    case (seg_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
      2:       rsp_ch.ready <= 1'b0;
      default: rsp_ch.ready <= (cycle_count % 3) != 0;
    endcase
  end

  // ------------------------------------------------------------------
  // Monitor: checks responses against the oldest prediction, then
  // predicts the response of a command accepted at this edge.
  // ------------------------------------------------------------------
  deque_rsp_t want;

  always @(posedge clk) begin
    cmd_fired = 1'b0;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsps.size() == 0) begin
          $error("response with none awaited: read_value %0d count %0d status %0d",
                 rsp_ch.read_value, rsp_ch.count, rsp_ch.status);
          failures++;
        end else begin
          want = awaited_rsps[0];
          awaited_rsps.delete(0);
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value,
                   rsp_ch.read_value);
            failures++;
          end
          if (rsp_ch.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
            failures++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            failures++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        cmd_fired = 1'b1;
        awaited_rsps.insert(awaited_rsps.size(),
                            apply_command(ids_op_t'(cmd_ch.operation), cmd_ch.value,
                                          cmd_ch.position));
      end
    end
  end

  // hard stop well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_deque_store: mismatch");
      $finish;
    end
  end

endmodule
